>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication form of the same check.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/red_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RED drop decision package
// Beat types, drop reason codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package red_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] queue_packets;
        logic [31:0] now;
        logic        fits;
    } t_in_beat;

    typedef struct packed {
        logic        accept;
        logic [1:0]  drop_reason;
        logic [31:0] avg_queue;
    } t_out_beat;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_EARLY  = 2'd1;
    localparam logic [1:0] REASON_FORCED = 2'd2;
    localparam logic [1:0] REASON_NOROOM = 2'd3;

    localparam logic FUNC_ARRIVAL   = 1'b0;
    localparam logic FUNC_DEPARTURE = 1'b1;

    localparam logic [2:0] REG_AVG_WEIGHT = 3'd0;
    localparam logic [2:0] REG_MIN_THRESH = 3'd1;
    localparam logic [2:0] REG_MAX_THRESH = 3'd2;
    localparam logic [2:0] REG_QUEUE_LIM  = 3'd3;
    localparam logic [2:0] REG_TX_TIME    = 3'd4;
    localparam logic [2:0] REG_RNG_SEED   = 3'd5;

    localparam logic [31:0] LFSR_MASK     = 32'h8020_0003;
    localparam logic [4:0]  DIV_LAST      = 5'd31;
    localparam logic [4:0]  DRAW_LAST     = 5'd15;
    localparam logic [16:0] COUNT_SAT     = 17'd65535;
    localparam logic [16:0] COUNT_RESET   = 17'h1FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_CHK,
        S_DEC_WR,
        S_EW1,
        S_EW2,
        S_EW3,
        S_DIV_INIT,
        S_DIV,
        S_CLASS,
        S_T1,
        S_T2,
        S_DRAW,
        S_FIN,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/red_queue_drop_decision_top.sv
`timescale 1ns / 1ps
// Sequence: a departure beat goes straight to the result states S_FIN and S_OUT; an arrival runs
// the EWMA update (or, with an empty queue, up to MAX_DECAY_STEPS idle decay steps instead),
// a 32-step divide, the count test and, on an early drop or count wrap, a 16-step random draw.
// Throughput: one beat at a time; the next beat is taken once the result has been taken.
// The sequencer uses the single shared multiplier and a bit-serial divider.
// Reset (synchronous, active low) loads register defaults, zero average, count -1, LFSR 1.
// ----------------------------------------------------------------------------
// RED queue drop decision
// Random early detection drop decision for an externally kept packet queue,
// computed by a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module red_queue_drop_decision_top #(
    parameter int unsigned MAX_DECAY_STEPS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  red_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output red_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers.
    logic [15:0] r_wq, r_lim, r_tt;
    logic [16:0] r_min, r_max;
    logic [31:0] r_seed;

    // Block state that lives across beats.
    logic [31:0] r_avg, n_avg;
    logic [31:0] r_idle, n_idle;
    logic [16:0] r_pc, n_pc;
    logic [15:0] r_draw, n_draw;
    logic [31:0] r_lfsr, n_lfsr;

    // Sequencer control.
    red_pkg::t_state r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_k, n_k;
    logic        r_out_valid, n_out_valid;

    // Working registers of the current beat.
    logic [15:0] r_q, n_q;
    logic        r_fits, n_fits;
    logic        r_func, n_func;
    logic [31:0] r_rem, n_rem;
    logic [33:0] r_tmp, n_tmp;
    logic [31:0] r_quo, n_quo;
    logic [16:0] r_drem, n_drem;
    logic [1:0]  r_reason, n_reason;
    logic [48:0] r_prod;
    red_pkg::t_out_beat r_out, n_out;

    // Shared multiplier; its product is registered every cycle.
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_prod;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [16:0] keep;
    logic [15:0] lim_eff, tt_eff;
    logic        in_acc;
    logic [32:0] ew_sum;
    logic [16:0] div_trial;
    logic        div_bit;
    logic [16:0] pc_inc;
    logic [31:0] lfsr_step;
    logic [49:0] test_lhs;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // Weight complement, and divisors of zero treated as one.
    assign keep    = 17'h10000 - {1'b0, r_wq};
    assign lim_eff = (r_lim == '0) ? 16'd1 : r_lim;
    assign tt_eff  = (r_tt == '0) ? 16'd1 : r_tt;

    assign o_in_stall  = (r_state != red_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign mul_prod = mul_a * mul_b;

    // Restoring divider: one quotient bit per cycle, remainder stays below the limit.
    assign div_trial = {r_drem[15:0], r_quo[31]};
    assign div_bit   = (div_trial >= {1'b0, lim_eff});

    // Packet count with saturation at the top.
    assign pc_inc = (r_pc == red_pkg::COUNT_SAT) ? r_pc : r_pc + 17'd1;

    // One Galois step of the right-shifting LFSR.
    assign lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ red_pkg::LFSR_MASK) : (r_lfsr >> 1);

    assign ew_sum   = {1'b0, r_tmp[31:0]} + {1'b0, r_prod[31:0]};
    assign test_lhs = {r_tmp, 16'd0};

    always_comb begin
        case (cfg_idx)
            red_pkg::REG_AVG_WEIGHT: prdata = {16'd0, r_wq};
            red_pkg::REG_MIN_THRESH: prdata = {15'd0, r_min};
            red_pkg::REG_MAX_THRESH: prdata = {15'd0, r_max};
            red_pkg::REG_QUEUE_LIM:  prdata = {16'd0, r_lim};
            red_pkg::REG_TX_TIME:    prdata = {16'd0, r_tt};
            red_pkg::REG_RNG_SEED:   prdata = r_seed;
            default:                 prdata = '0;
        endcase
    end

    // Next state, multiplier operands and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_avg       = r_avg;
        n_idle      = r_idle;
        n_pc        = r_pc;
        n_draw      = r_draw;
        n_lfsr      = r_lfsr;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_q         = r_q;
        n_fits      = r_fits;
        n_func      = r_func;
        n_rem       = r_rem;
        n_tmp       = r_tmp;
        n_quo       = r_quo;
        n_drem      = r_drem;
        n_reason    = r_reason;
        n_out       = r_out;
        mul_a       = r_avg;
        mul_b       = keep;

        case (r_state)
            red_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_q      = i_in_data.queue_packets;
                    n_fits   = i_in_data.fits;
                    n_func   = i_in_data.func;
                    n_reason = red_pkg::REASON_NONE;
                    n_k      = '0;
                    n_rem    = i_in_data.now - r_idle;
                    if (i_in_data.func == red_pkg::FUNC_DEPARTURE) begin
                        if (i_in_data.queue_packets == '0) begin
                            n_idle = i_in_data.now;
                        end
                        n_state = red_pkg::S_FIN;
                    end else if (i_in_data.queue_packets == '0) begin
                        n_state = red_pkg::S_DEC_CHK;
                    end else begin
                        n_state = red_pkg::S_EW1;
                    end
                end
            end
            red_pkg::S_DEC_CHK: begin
                // Each idle step removes one transmission time from the elapsed time.
                if ((r_k < 16'(MAX_DECAY_STEPS)) && (r_rem >= {16'd0, tt_eff})) begin
                    n_rem   = r_rem - {16'd0, tt_eff};
                    n_k     = r_k + 16'd1;
                    n_state = red_pkg::S_DEC_WR;
                end else begin
                    n_state = red_pkg::S_DIV_INIT;
                end
            end
            red_pkg::S_DEC_WR: begin
                n_avg   = r_prod[47:16];
                n_state = red_pkg::S_DEC_CHK;
            end
            red_pkg::S_EW1: begin
                n_state = red_pkg::S_EW2;
            end
            red_pkg::S_EW2: begin
                n_tmp   = {2'd0, r_prod[47:16]};
                mul_a   = {16'd0, r_q};
                mul_b   = {1'b0, r_wq};
                n_state = red_pkg::S_EW3;
            end
            red_pkg::S_EW3: begin
                n_avg   = ew_sum[32] ? 32'hFFFF_FFFF : ew_sum[31:0];
                n_state = red_pkg::S_DIV_INIT;
            end
            red_pkg::S_DIV_INIT: begin
                n_quo   = r_avg;
                n_drem  = '0;
                n_cnt   = '0;
                n_state = red_pkg::S_DIV;
            end
            red_pkg::S_DIV: begin
                n_drem  = div_bit ? (div_trial - {1'b0, lim_eff}) : div_trial;
                n_quo   = {r_quo[30:0], div_bit};
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == red_pkg::DIV_LAST) begin
                    n_state = red_pkg::S_CLASS;
                end
            end
            red_pkg::S_CLASS: begin
                n_cnt = '0;
                mul_a = {15'd0, pc_inc};
                mul_b = r_quo[16:0] - r_min;
                if ((r_quo >= {15'd0, r_min}) && (r_quo <= {15'd0, r_max})) begin
                    n_pc = pc_inc;
                    if (pc_inc == '0) begin
                        n_state = red_pkg::S_DRAW;
                    end else if (r_max == r_min) begin
                        n_reason = red_pkg::REASON_EARLY;
                        n_pc     = '0;
                        n_state  = red_pkg::S_DRAW;
                    end else begin
                        n_state = red_pkg::S_T1;
                    end
                end else if (r_quo > {15'd0, r_max}) begin
                    n_reason = red_pkg::REASON_FORCED;
                    n_pc     = '0;
                    n_state  = red_pkg::S_FIN;
                end else begin
                    n_pc    = red_pkg::COUNT_RESET;
                    n_state = red_pkg::S_FIN;
                end
            end
            red_pkg::S_T1: begin
                n_tmp   = r_prod[33:0];
                mul_a   = {16'd0, r_draw};
                mul_b   = r_max - r_min;
                n_state = red_pkg::S_T2;
            end
            red_pkg::S_T2: begin
                // Cross-multiplied form of count * p >= draw.
                if (test_lhs >= {1'b0, r_prod}) begin
                    n_reason = red_pkg::REASON_EARLY;
                    n_pc     = '0;
                    n_state  = red_pkg::S_DRAW;
                end else begin
                    n_state = red_pkg::S_FIN;
                end
            end
            red_pkg::S_DRAW: begin
                n_lfsr = lfsr_step;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == red_pkg::DRAW_LAST) begin
                    n_draw  = lfsr_step[15:0];
                    n_state = red_pkg::S_FIN;
                end
            end
            red_pkg::S_FIN: begin
                n_out.avg_queue   = r_avg;
                n_out.accept      = 1'b0;
                n_out.drop_reason = r_reason;
                if ((r_func == red_pkg::FUNC_ARRIVAL) && (r_reason == red_pkg::REASON_NONE)) begin
                    if (r_fits) begin
                        n_out.accept = 1'b1;
                    end else begin
                        n_out.drop_reason = red_pkg::REASON_NOROOM;
                    end
                end
                n_out_valid = 1'b1;
                n_state     = red_pkg::S_OUT;
            end
            red_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = red_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = red_pkg::S_IDLE;
            end
        endcase

        // A seed write reloads the LFSR; a zero seed would lock it.
        if (cfg_wr && (cfg_idx == red_pkg::REG_RNG_SEED)) begin
            n_lfsr = (pwdata == '0) ? 32'd1 : pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= red_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_idle      <= '0;
            r_pc        <= red_pkg::COUNT_RESET;
            r_draw      <= '0;
            r_lfsr      <= 32'd1;
            r_wq        <= 16'd128;
            r_min       <= 17'd16384;
            r_max       <= 17'd49152;
            r_lim       <= 16'd1000;
            r_tt        <= 16'd1;
            r_seed      <= 32'd1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_avg       <= n_avg;
            r_idle      <= n_idle;
            r_pc        <= n_pc;
            r_draw      <= n_draw;
            r_lfsr      <= n_lfsr;
            if (cfg_wr) begin
                case (cfg_idx)
                    red_pkg::REG_AVG_WEIGHT: r_wq   <= pwdata[15:0];
                    red_pkg::REG_MIN_THRESH: r_min  <= pwdata[16:0];
                    red_pkg::REG_MAX_THRESH: r_max  <= pwdata[16:0];
                    red_pkg::REG_QUEUE_LIM:  r_lim  <= pwdata[15:0];
                    red_pkg::REG_TX_TIME:    r_tt   <= pwdata[15:0];
                    red_pkg::REG_RNG_SEED:   r_seed <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers carry no reset; the sequencer loads them before use.
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_q      <= n_q;
        r_fits   <= n_fits;
        r_func   <= n_func;
        r_rem    <= n_rem;
        r_tmp    <= n_tmp;
        r_quo    <= n_quo;
        r_drem   <= n_drem;
        r_reason <= n_reason;
        r_prod   <= mul_prod;
        r_out    <= n_out;
    end

    // While a result waits, no new beat may enter.
    `ASSERT_IMPL(a_out_blocks_in, r_out_valid, o_in_stall, "input taken while result pending")
    // A departure never enqueues and never reports a drop.
    `ASSERT_IMPL(a_dep_result, r_out_valid && (r_func == red_pkg::FUNC_DEPARTURE),
        !r_out.accept && (r_out.drop_reason == red_pkg::REASON_NONE), "bad departure result")
    // An accepted packet carries no drop reason.
    `ASSERT_IMPL(a_accept_reason, r_out_valid && r_out.accept,
        r_out.drop_reason == red_pkg::REASON_NONE, "accept with drop reason")
    // The LFSR must never lock at zero.
    `ASSERT_CLK(a_lfsr_live, r_lfsr != '0, "LFSR reached zero")

endmodule
